>>> rtl/core/svo_pkg.sv
// Shared types and constants for the sparse voxel octree store.
// No dependencies; used by svo_ctrl, the top level and the testbench.
package svo_pkg;

  localparam int unsigned CUBE_SIDE_DEF  = 32;
  localparam int unsigned POOL_NODES_DEF = 1024;
  localparam int unsigned CELL_BITS_DEF  = 16;
  localparam int unsigned CHILDREN       = 8;
  localparam int unsigned COORD_W        = 5;
  localparam int unsigned ID_W           = 16;
  localparam int unsigned COUNT_W        = 16;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_RD,
    ST_CHK,
    ST_CLR,
    ST_LINK,
    ST_CRD,
    ST_CELL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic is_write;
    logic in_range;
  } item_flags_t;

endpackage

>>> rtl/core/svo_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module svo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/svo_ctrl.sv
// Octree walker: node and cell memories, descend/split/write sequencer,
// result register. Depends on svo_pkg and svo_ram.
module svo_ctrl #(
  parameter int unsigned CUBE_SIDE  = svo_pkg::CUBE_SIDE_DEF,
  parameter int unsigned POOL_NODES = svo_pkg::POOL_NODES_DEF,
  parameter int unsigned CELL_BITS  = svo_pkg::CELL_BITS_DEF,
  localparam int unsigned L         = $clog2(CUBE_SIDE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  svo_pkg::item_flags_t          req_flags_i,
  input  logic [L-1:0]                  ux_i,
  input  logic [L-1:0]                  uy_i,
  input  logic [L-1:0]                  uz_i,
  input  logic [CELL_BITS-1:0]          id_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [svo_pkg::ID_W-1:0]      res_value_o,
  output svo_pkg::status_e              res_status_o,
  output logic [svo_pkg::COUNT_W-1:0]   res_count_o
);

  localparam int unsigned NW     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned NUW    = $clog2(POOL_NODES + 1);
  localparam int unsigned CAW    = NW + 3;
  localparam int unsigned WORD_W = 1 + NW + 8;
  localparam int unsigned LVL_W  = $clog2(L + 1);
  localparam logic [LVL_W-1:0] BOTTOM = LVL_W'(L - 1);

  // node word: {split, child base, cell-written mask}
  svo_pkg::state_e       state_q, state_d;
  logic                  write_q, write_d;
  logic [L-1:0]          ux_q, uy_q, uz_q, ux_d, uy_d, uz_d;
  logic [CELL_BITS-1:0]  id_q, id_d;
  logic [NW-1:0]         node_q, node_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [WORD_W-1:0]     word_q, word_d;
  logic [NUW-1:0]        nused_q, nused_d;
  logic [svo_pkg::COUNT_W-1:0] count_q, count_d;
  logic [2:0]            clr_q, clr_d;
  logic [CELL_BITS-1:0]  value_q, value_d;
  svo_pkg::status_e      status_q, status_d;
  logic                  ovalid_q, ovalid_d;
  logic [svo_pkg::ID_W-1:0] ovalue_q, ovalue_d;
  svo_pkg::status_e      ostatus_q, ostatus_d;
  logic [svo_pkg::COUNT_W-1:0] ocount_q, ocount_d;

  logic                  node_we;
  logic [NW-1:0]         node_waddr, node_raddr;
  logic [WORD_W-1:0]     node_wdata, node_rdata;
  logic                  cell_we;
  logic [CAW-1:0]        cell_addr;
  logic [CELL_BITS-1:0]  cell_rdata;

  logic [LVL_W-1:0]      bitpos;
  logic [2:0]            oct;
  logic [NW:0]           child;
  logic [31:0]           need;
  logic                  over;
  logic [CELL_BITS-1:0]  old;
  logic [7:0]            mask_cur;
  logic [7:0]            mask_set;

  svo_ram #(.WIDTH(WORD_W), .DEPTH(POOL_NODES)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  svo_ram #(.WIDTH(CELL_BITS), .DEPTH(POOL_NODES * svo_pkg::CHILDREN)) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(cell_addr),
    .wdata_i(id_q),
    .raddr_i(cell_addr),
    .rdata_o(cell_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= svo_pkg::ST_IDLE;
      nused_q  <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      nused_q  <= nused_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    write_q   <= write_d;
    ux_q      <= ux_d;
    uy_q      <= uy_d;
    uz_q      <= uz_d;
    id_q      <= id_d;
    node_q    <= node_d;
    lvl_q     <= lvl_d;
    word_q    <= word_d;
    value_q   <= value_d;
    status_q  <= status_d;
    ovalue_q  <= ovalue_d;
    ostatus_q <= ostatus_d;
    ocount_q  <= ocount_d;
  end

  // octant at the current level: one bit of each offset coordinate
  assign bitpos   = BOTTOM - lvl_q;
  assign oct      = {uz_q[bitpos], uy_q[bitpos], ux_q[bitpos]};
  assign child    = (NW + 1)'(node_rdata[NW+7:8]) + (NW + 1)'(oct);
  assign need     = 32'(BOTTOM - lvl_q) << 3;
  assign over     = (32'(nused_q) + need) > 32'(POOL_NODES);
  assign mask_cur = word_q[7:0];
  assign old      = mask_cur[oct] ? cell_rdata : '0;
  assign cell_addr = {node_q, oct};

  always_comb begin
    mask_set      = mask_cur;
    mask_set[oct] = 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    write_d   = write_q;
    ux_d      = ux_q;
    uy_d      = uy_q;
    uz_d      = uz_q;
    id_d      = id_q;
    node_d    = node_q;
    lvl_d     = lvl_q;
    word_d    = word_q;
    nused_d   = nused_q;
    count_d   = count_q;
    clr_d     = clr_q;
    value_d   = value_q;
    status_d  = status_q;
    ovalid_d  = ovalid_q && !res_ready_i;
    ovalue_d  = ovalue_q;
    ostatus_d = ostatus_q;
    ocount_d  = ocount_q;
    node_we    = 1'b0;
    node_waddr = node_q;
    node_wdata = '0;
    node_raddr = node_q;
    cell_we    = 1'b0;
    req_ready_o = (state_q == svo_pkg::ST_IDLE);

    unique case (state_q)
      svo_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          write_d  = req_flags_i.is_write;
          ux_d     = ux_i;
          uy_d     = uy_i;
          uz_d     = uz_i;
          id_d     = id_i;
          node_d   = '0;
          lvl_d    = '0;
          value_d  = '0;
          status_d = svo_pkg::STAT_OK;
          if (!req_flags_i.in_range) begin
            status_d = req_flags_i.is_write ? svo_pkg::STAT_RANGE : svo_pkg::STAT_OK;
            state_d  = svo_pkg::ST_DONE;
          end else if (nused_q == '0) begin
            if (!req_flags_i.is_write) begin
              state_d = svo_pkg::ST_DONE;
            end else if ((32'(BOTTOM) << 3) + 32'd1 > 32'(POOL_NODES)) begin
              status_d = svo_pkg::STAT_FULL;
              state_d  = svo_pkg::ST_DONE;
            end else begin
              state_d = svo_pkg::ST_ROOT;
            end
          end else begin
            state_d = svo_pkg::ST_RD;
          end
        end
      end
      svo_pkg::ST_ROOT: begin
        node_we    = 1'b1;
        node_waddr = '0;
        nused_d    = NUW'(1);
        word_d     = '0;
        clr_d      = '0;
        state_d    = (BOTTOM == '0) ? svo_pkg::ST_CRD : svo_pkg::ST_CLR;
      end
      svo_pkg::ST_RD: begin
        state_d = svo_pkg::ST_CHK;
      end
      svo_pkg::ST_CHK: begin
        if (node_rdata[WORD_W-1] && lvl_q < BOTTOM && child < (NW + 1)'(POOL_NODES)) begin
          node_d  = child[NW-1:0];
          lvl_d   = lvl_q + 1'b1;
          state_d = svo_pkg::ST_RD;
        end else begin
          word_d = node_rdata;
          clr_d  = '0;
          if (!write_q) begin
            state_d = svo_pkg::ST_CRD;
          end else if (over) begin
            status_d = svo_pkg::STAT_FULL;
            state_d  = svo_pkg::ST_DONE;
          end else if (lvl_q < BOTTOM) begin
            state_d = svo_pkg::ST_CLR;
          end else begin
            state_d = svo_pkg::ST_CRD;
          end
        end
      end
      svo_pkg::ST_CLR: begin
        // fresh children: leaf, nothing written
        node_we    = 1'b1;
        node_waddr = NW'(nused_q) + NW'(clr_q);
        clr_d      = clr_q + 1'b1;
        if (clr_q == 3'd7) begin
          state_d = svo_pkg::ST_LINK;
        end
      end
      svo_pkg::ST_LINK: begin
        node_we    = 1'b1;
        node_wdata = {1'b1, NW'(nused_q), word_q[7:0]};
        node_d     = NW'(nused_q) + NW'(oct);
        nused_d    = nused_q + NUW'(svo_pkg::CHILDREN);
        lvl_d      = lvl_q + 1'b1;
        word_d     = '0;
        state_d    = (lvl_q + 1'b1 == BOTTOM) ? svo_pkg::ST_CRD : svo_pkg::ST_CLR;
      end
      svo_pkg::ST_CRD: begin
        state_d = svo_pkg::ST_CELL;
      end
      svo_pkg::ST_CELL: begin
        if (!write_q) begin
          value_d = old;
        end else begin
          cell_we    = 1'b1;
          node_we    = 1'b1;
          node_wdata = {word_q[WORD_W-1:8], mask_set};
          if (id_q != '0 && old == '0) begin
            count_d = count_q + 1'b1;
          end else if (id_q == '0 && old != '0 && count_q != '0) begin
            count_d = count_q - 1'b1;
          end
        end
        state_d = svo_pkg::ST_DONE;
      end
      svo_pkg::ST_DONE: begin
        if (!ovalid_q || res_ready_i) begin
          ovalid_d  = 1'b1;
          ovalue_d  = svo_pkg::ID_W'(value_q);
          ostatus_d = status_q;
          ocount_d  = count_q;
          state_d   = svo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = svo_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_valid_o  = ovalid_q;
  assign res_value_o  = ovalue_q;
  assign res_status_o = ostatus_q;
  assign res_count_o  = ocount_q;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nused_q) <= 32'(POOL_NODES))
    else $error("node pool overrun");

  a_cell_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_we |-> (state_q == svo_pkg::ST_CELL && write_q && status_q == svo_pkg::STAT_OK))
    else $error("cell write outside a committed write");

  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svo_pkg::ST_DONE && !write_q) |-> status_q == svo_pkg::STAT_OK)
    else $error("read reports an error");

  a_count_only_in_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q) == svo_pkg::ST_CELL)
    else $error("count changed outside cell update");

endmodule

>>> rtl/core/sparse_voxel_octree_store.sv
// Request to result: one node read per level descended, plus, for each node split on
// a write, eight child clears and a link; out-of-range requests and empty-tree reads
// go straight to the result register.
// One request at a time: the next is taken once the result has registered, and a
// result not yet taken by the receiver holds the next request back.
// Reset: asynchronous, active low; empties the tree (no clearing pass), count to 0.
module sparse_voxel_octree_store #(
  parameter int unsigned CUBE_SIDE  = svo_pkg::CUBE_SIDE_DEF,
  parameter int unsigned POOL_NODES = svo_pkg::POOL_NODES_DEF,
  parameter int unsigned CELL_BITS  = svo_pkg::CELL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[4:0], pos_y[9:5], pos_z[14:10], block_id[30:15], zero[31]
  input  logic [31:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_value[15:0], status[17:16], occupied_count[33:18], zero[39:34]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned L    = $clog2(CUBE_SIDE);
  localparam int unsigned HALF = CUBE_SIDE / 2;

  logic signed [9:0] xo, yo, zo;
  logic              in_range;
  svo_pkg::item_flags_t flags;
  logic [svo_pkg::ID_W-1:0]    res_value;
  svo_pkg::status_e            res_status;
  logic [svo_pkg::COUNT_W-1:0] res_count;

  // shift coordinates so the cube runs from zero
  assign xo = $signed({{5{s_axis_tdata[4]}}, s_axis_tdata[4:0]}) + $signed(10'(HALF));
  assign yo = $signed({{5{s_axis_tdata[9]}}, s_axis_tdata[9:5]}) + $signed(10'(HALF));
  assign zo = $signed({{5{s_axis_tdata[14]}}, s_axis_tdata[14:10]}) + $signed(10'(HALF));

  assign in_range = !xo[9] && (xo[8:0] < 9'(CUBE_SIDE)) &&
                    !yo[9] && (yo[8:0] < 9'(CUBE_SIDE)) &&
                    !zo[9] && (zo[8:0] < 9'(CUBE_SIDE));

  assign flags.is_write = s_axis_tuser;
  assign flags.in_range = in_range;

  svo_ctrl #(
    .CUBE_SIDE (CUBE_SIDE),
    .POOL_NODES(POOL_NODES),
    .CELL_BITS (CELL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_flags_i (flags),
    .ux_i        (xo[L-1:0]),
    .uy_i        (yo[L-1:0]),
    .uz_i        (zo[L-1:0]),
    .id_i        (CELL_BITS'(s_axis_tdata[30:15])),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_value_o (res_value),
    .res_status_o(res_status),
    .res_count_o (res_count)
  );

  assign m_axis_tdata = {6'd0, res_count, res_status, res_value};

endmodule

>>> verif/tb_sparse_voxel_octree_store.sv
// Self-checking testbench for sparse_voxel_octree_store: directed and random
// read/write requests, checked against an in-bench octree predictor.
// Depends on svo_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_sparse_voxel_octree_store;

  localparam int HALF = svo_pkg::CUBE_SIDE_DEF / 2;
  localparam int POOL = svo_pkg::POOL_NODES_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_LEN = 300;

  typedef enum logic {OP_READ = 1'b0, OP_WRITE = 1'b1} op_e;

  typedef struct {
    logic [15:0]      value;
    svo_pkg::status_e status;
    logic [15:0]      count;
  } octree_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  sparse_voxel_octree_store u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic        split_q[POOL];
  int          child_base_q[POOL];
  logic [15:0] cells_q[POOL*8];
  int          nodes_used;
  int          nonzero;

  octree_resp_t resp_q[$];
  int mismatches = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  function automatic logic [2:0] octant_of(int x, int y, int z, int cx, int cy, int cz);
    return {z >= cz, y >= cy, x >= cx};
  endfunction

  function automatic void step_down(int x, int y, int z, inout int size,
                                    inout int cx, inout int cy, inout int cz);
    size = size >> 1;
    cx = (x >= cx) ? cx + size : cx - size;
    cy = (y >= cy) ? cy + size : cy - size;
    cz = (z >= cz) ? cz + size : cz - size;
  endfunction

  function automatic void walk_tree(int x, int y, int z, output int node, output int size,
                                    output int cx, output int cy, output int cz);
    int child;
    node = 0; size = HALF; cx = 0; cy = 0; cz = 0;
    while (size > 1 && node < POOL && split_q[node]) begin
      child = child_base_q[node] + octant_of(x, y, z, cx, cy, cz);
      if (child >= POOL) break;
      node = child;
      step_down(x, y, z, size, cx, cy, cz);
    end
  endfunction

  function automatic void clear_node(int n);
    split_q[n] = 1'b0;
    child_base_q[n] = 0;
    for (int i = 0; i < 8; i++) cells_q[n*8+i] = '0;
  endfunction

  function automatic svo_pkg::status_e write_tree(int x, int y, int z, logic [15:0] id);
    int node, size, cx, cy, cz, need, base, idx;
    if (x < -HALF || x >= HALF || y < -HALF || y >= HALF || z < -HALF || z >= HALF)
      return svo_pkg::STAT_RANGE;
    if (nodes_used == 0) begin
      size = HALF;
      need = 1;
    end else begin
      walk_tree(x, y, z, node, size, cx, cy, cz);
      need = 0;
    end
    for (int s = size; s > 1; s = s >> 1) need += 8;
    if (nodes_used + need > POOL) return svo_pkg::STAT_FULL;
    if (nodes_used == 0) begin
      clear_node(0);
      nodes_used = 1;
      walk_tree(x, y, z, node, size, cx, cy, cz);
    end
    while (size > 1) begin
      base = nodes_used;
      for (int i = 0; i < 8; i++) clear_node(base + i);
      split_q[node] = 1'b1;
      child_base_q[node] = base;
      nodes_used += 8;
      node = base + octant_of(x, y, z, cx, cy, cz);
      step_down(x, y, z, size, cx, cy, cz);
    end
    idx = node*8 + octant_of(x, y, z, cx, cy, cz);
    if (id != 0 && cells_q[idx] == 0) nonzero++;
    else if (id == 0 && cells_q[idx] != 0 && nonzero > 0) nonzero--;
    cells_q[idx] = id;
    return svo_pkg::STAT_OK;
  endfunction

  function automatic octree_resp_t predict_octree(op_e op, int x, int y, int z,
                                                  logic [15:0] id);
    octree_resp_t r;
    int node, size, cx, cy, cz;
    r.value = '0;
    r.status = svo_pkg::STAT_OK;
    if (op == OP_WRITE) begin
      r.status = write_tree(x, y, z, id);
    end else if (nodes_used != 0 && x >= -HALF && x < HALF && y >= -HALF && y < HALF &&
                 z >= -HALF && z < HALF) begin
      walk_tree(x, y, z, node, size, cx, cy, cz);
      r.value = cells_q[node*8 + octant_of(x, y, z, cx, cy, cz)];
    end
    r.count = nonzero[15:0];
    return r;
  endfunction

  // Send one request; valid stays high into the next call unless a gap is drawn.
  task automatic send_item(op_e op, int x, int y, int z, logic [15:0] id);
    logic [4:0] px, py, pz;
    px = x[4:0]; py = y[4:0]; pz = z[4:0];
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, id, pz, py, px};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    resp_q.push_back(predict_octree(op, x, y, z, id));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_id();
    return ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom());
  endfunction

  // Result check
  always @(posedge clk_i) begin
    octree_resp_t e;
    logic [15:0] got_val, got_cnt;
    logic [1:0]  got_st;
    if (m_axis_tvalid && m_axis_tready) begin
      got_val = m_axis_tdata[15:0];
      got_st  = m_axis_tdata[17:16];
      got_cnt = m_axis_tdata[33:18];
      if (resp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = resp_q.pop_front();
        if (got_val !== e.value || got_st !== e.status || got_cnt !== e.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result error: exp val %h st %0d cnt %0d, got val %h st %0d cnt %0d",
                     e.value, e.status, e.count, got_val, got_st, got_cnt);
        end
      end
    end
  end

  // Receiver ready, with long holds counted here
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // Watchdog: cycles with no request or result accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_READ, 0, 0, 0, 16'hFFFF);           // empty tree
    send_item(OP_READ, -16, 15, -16, 16'h0);
    send_item(OP_WRITE, -16, -16, -16, 16'hFFFF);    // creates root
    send_item(OP_READ, -16, -16, -16, 16'h0);
    send_item(OP_READ, 15, 15, 15, 16'h0);           // coarse leaf
    send_item(OP_READ, -15, -16, -16, 16'h0);
    send_item(OP_WRITE, 15, 15, 15, 16'hAAAA);
    send_item(OP_WRITE, 15, -16, 15, 16'h5555);
    send_item(OP_READ, 15, 15, 15, 16'h0);
    send_item(OP_READ, 15, -16, 15, 16'h0);
    send_item(OP_WRITE, 15, 15, 15, 16'h0);          // nonzero to zero
    send_item(OP_WRITE, 15, 15, 15, 16'h0);          // zero over zero
    send_item(OP_WRITE, 0, -1, 7, 16'h0);            // zero still splits
    send_item(OP_READ, 15, 15, 15, 16'h0);
    send_item(OP_WRITE, -1, 0, -8, 16'h0001);
    send_item(OP_WRITE, -1, 0, -8, 16'h8000);        // overwrite nonzero
    send_item(OP_READ, -1, 0, -8, 16'h0);
    send_item(OP_READ, 14, 14, 14, 16'h0);
    wait_drained();
  endtask

  // Mostly local 4x4x4 region so the tree gets deep without draining the pool.
  task automatic test_random(int n, int base);
    int x, y, z;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        x = $urandom_range(0, 31) - 16;
        y = $urandom_range(0, 31) - 16;
        z = $urandom_range(0, 31) - 16;
      end else begin
        x = base + $urandom_range(0, 3);
        y = base + $urandom_range(0, 3);
        z = base + $urandom_range(0, 3);
      end
      send_item(op_e'($urandom_range(0, 1)), x, y, z, rand_id());
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 20; i++)
      send_item(op_e'($urandom_range(0, 1)), -16 + $urandom_range(0, 3),
                12 + $urandom_range(0, 3), -4 + $urandom_range(0, 3), rand_id());
    wait_drained();
  endtask

  task automatic test_pool_full();
    for (int i = 0; i < 250; i++)
      send_item(($urandom_range(0, 3) == 0) ? OP_READ : OP_WRITE, $urandom_range(0, 31) - 16,
                $urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16, rand_id());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    tx_idle = 11; rx_idle = 46;
    test_random(420, -16);
    tx_idle = 46; rx_idle = 11;
    test_random(420, 12);
    tx_idle = 0; rx_idle = 0;
    test_random(420, -4);
    test_backpressure();
    test_pool_full();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && resp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/svo_pkg.sv
rtl/core/svo_ram.sv
rtl/core/svo_ctrl.sv
rtl/core/sparse_voxel_octree_store.sv
verif/tb_sparse_voxel_octree_store.sv
